@@ rtl/bnps_pkg.sv @@
// Shared types and constants for the binned nearest peak search.
package bnps_pkg;

    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_LOAD  = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;

    localparam logic [1:0] ST_FOUND = 2'd0;
    localparam logic [1:0] ST_NONE  = 2'd1;
    localparam logic [1:0] ST_ERROR = 2'd2;

    // Divider request and response
    typedef struct packed {
        logic        go;
        logic [32:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [32:0] quotient;
        logic        exact;
    } div_rsp_t;

endpackage

@@ rtl/bnps_ram.sv @@
// Generic single-port synchronous RAM with registered read.
module bnps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

@@ rtl/bnps_div.sv @@
// Restoring divider, one quotient bit per cycle, 33-bit dividend.
module bnps_div (
    input  logic                clk,
    input  logic                rst_n,
    input  bnps_pkg::div_req_t  req,
    output bnps_pkg::div_rsp_t  rsp
);
    import bnps_pkg::*;

    logic [32:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [33:0] trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        trial     = '0;
        if (req.go)
        begin
            quo_next = req.dividend;
            rem_next = '0;
            dvs_next = req.divisor;
            cnt_next = 6'd33;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            trial = {rem_reg, quo_reg[32]} - {2'b0, dvs_reg};
            if (!trial[33])
            begin
                rem_next = trial[32:0];
                quo_next = {quo_reg[31:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[31:0], quo_reg[32]};
                quo_next = {quo_reg[31:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;
    assign rsp.exact    = (rem_reg == '0);
endmodule

@@ rtl/binned_nearest_peak_search.sv @@
// Top level of the binned nearest peak search.
//
// One command at a time: start is taken while busy is low. A clear, or a
// dropped mode 3, keeps busy high through S_NWAIT after it is taken, as
// does the first load into an empty table. Any later load reads the last
// peak, checks order and room, divides for its bin, fills in the empty bins
// and opens the new bin when it needs one, then stores the peak. A load
// refused for order or a full store ends after the check, one refused for
// its bin after the division. A query runs two bin divisions, clamps the
// window, scans bins from each end of it, runs a binary search, then reads
// the neighbours and compares, so its length depends on the window and the
// number of peaks. A query refused early (error seen or empty table) goes
// straight to its result. The shared serial divider and the single port of
// each memory set the length of each command. A query ends with exactly one
// result, shown on the result ports for one cycle with result_valid high;
// the receiver cannot stall it. Clear and load give no result, and mode 3
// is dropped. bin_width is written through its own channel while the block
// is idle; a value of zero acts as one.
module binned_nearest_peak_search #(
    parameter int MAX_PEAKS = 1024,
    parameter int MAX_BINS  = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  mode,
    input  logic [31:0] position,
    input  logic [31:0] tolerance,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    output logic        result_valid,
    output logic [1:0]  status,
    output logic [9:0]  peak_index,
    output logic [31:0] peak_position
);
    import bnps_pkg::*;

    localparam int PW = $clog2(MAX_PEAKS);
    localparam int BW = $clog2(MAX_BINS);
    localparam int CW = PW + 1;   // peak counts up to MAX_PEAKS
    localparam int NW = BW + 1;   // bin counts up to MAX_BINS

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_LRD     = 5'd1;
    localparam logic [4:0] S_LCHK    = 5'd2;
    localparam logic [4:0] S_LDIV    = 5'd3;
    localparam logic [4:0] S_LFILL   = 5'd4;
    localparam logic [4:0] S_LSTORE  = 5'd5;
    localparam logic [4:0] S_QLO     = 5'd6;
    localparam logic [4:0] S_QHI     = 5'd7;
    localparam logic [4:0] S_QCLAMP  = 5'd8;
    localparam logic [4:0] S_SFRD    = 5'd9;
    localparam logic [4:0] S_SFCHK   = 5'd10;
    localparam logic [4:0] S_SBRD    = 5'd11;
    localparam logic [4:0] S_SBCHK   = 5'd12;
    localparam logic [4:0] S_BSRD    = 5'd13;
    localparam logic [4:0] S_BSCHK   = 5'd14;
    localparam logic [4:0] S_NRD     = 5'd15;
    localparam logic [4:0] S_NRD2    = 5'd16;
    localparam logic [4:0] S_NPICK   = 5'd17;
    localparam logic [4:0] S_OUT     = 5'd18;
    localparam logic [4:0] S_NWAIT   = 5'd19;

    logic [4:0]    state_reg, state_next;
    logic [31:0]   width_reg, width_next;
    logic [CW-1:0] pcount_reg, pcount_next;
    logic [NW-1:0] bcount_reg, bcount_next;
    logic [31:0]   base_reg, base_next;
    logic          err_reg, err_next;

    logic [31:0]   pos_reg, pos_next;
    logic [31:0]   tol_reg, tol_next;
    logic [NW-1:0] idx_reg, idx_next;     // load target bin / fill cursor
    logic [33:0]   lo_reg, lo_next;       // signed bin indices
    logic [33:0]   hi_reg, hi_next;
    logic [CW-1:0] left_reg, left_next;
    logic [CW-1:0] right_reg, right_next;
    logic [31:0]   cand_reg, cand_next;   // peak at left
    logic          rv_reg, rv_next;
    logic [1:0]    st_reg, st_next;
    logic [9:0]    pi_reg, pi_next;
    logic [31:0]   pp_reg, pp_next;

    // memories
    logic          pk_we;
    logic [PW-1:0] pk_addr;
    logic [31:0]   pk_wdata, pk_rdata;
    logic          bf_we, bl_we;
    logic [BW-1:0] bn_addr;
    logic [CW-1:0] bf_wdata, bl_wdata, bf_rdata, bl_rdata;

    bnps_ram #(.WIDTH(32), .DEPTH(MAX_PEAKS)) u_peaks (
        .clk(clk), .we(pk_we), .addr(pk_addr), .wdata(pk_wdata), .rdata(pk_rdata)
    );
    bnps_ram #(.WIDTH(CW), .DEPTH(MAX_BINS)) u_bin_first (
        .clk(clk), .we(bf_we), .addr(bn_addr), .wdata(bf_wdata), .rdata(bf_rdata)
    );
    bnps_ram #(.WIDTH(CW), .DEPTH(MAX_BINS)) u_bin_last (
        .clk(clk), .we(bl_we), .addr(bn_addr), .wdata(bl_wdata), .rdata(bl_rdata)
    );

    div_req_t dreq;
    div_rsp_t drsp;
    bnps_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    logic [31:0] wused;
    logic [32:0] lo_mag, hi_sum;
    logic        lo_neg;
    logic [CW-1:0] mid, pc_m1;
    logic [31:0] d_cur, d_prev;
    logic [33:0] q_ext, bc_ext;

    assign wused     = (width_reg == '0) ? 32'd1 : width_reg;
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = !busy;
    assign mid       = left_reg + ((right_reg - left_reg) >> 1);
    assign pc_m1     = pcount_reg - CW'(1);
    assign bc_ext    = {{(34-NW){1'b0}}, bcount_reg};
    assign q_ext     = {1'b0, drsp.quotient};

    always_comb
    begin
        state_next  = state_reg;
        width_next  = width_reg;
        pcount_next = pcount_reg;
        bcount_next = bcount_reg;
        base_next   = base_reg;
        err_next    = err_reg;
        pos_next    = pos_reg;
        tol_next    = tol_reg;
        idx_next    = idx_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        left_next   = left_reg;
        right_next  = right_reg;
        cand_next   = cand_reg;
        rv_next     = 1'b0;
        st_next     = st_reg;
        pi_next     = pi_reg;
        pp_next     = pp_reg;
        pk_we       = 1'b0;
        pk_addr     = pc_m1[PW-1:0];
        pk_wdata    = pos_reg;
        bf_we       = 1'b0;
        bl_we       = 1'b0;
        bn_addr     = idx_reg[BW-1:0];
        bf_wdata    = pcount_reg;
        bl_wdata    = pcount_reg;
        dreq        = '0;
        lo_mag      = '0;
        lo_neg      = 1'b0;
        hi_sum      = '0;
        d_cur       = '0;
        d_prev      = '0;

        if (cfg_valid && cfg_ready)
        begin
            width_next = cfg_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    pos_next = position;
                    tol_next = tolerance;
                    case (mode)
                        MODE_CLEAR:
                        begin
                            pcount_next = '0;
                            bcount_next = '0;
                            base_next   = '0;
                            err_next    = 1'b0;
                            state_next  = S_NWAIT;
                        end
                        MODE_LOAD:
                        begin
                            if (pcount_reg == '0)
                            begin
                                base_next   = position;
                                pk_we       = 1'b1;
                                pk_addr     = '0;
                                pk_wdata    = position;
                                bf_we       = 1'b1;
                                bl_we       = 1'b1;
                                bn_addr     = '0;
                                bf_wdata    = '0;
                                bl_wdata    = CW'(1);
                                bcount_next = NW'(1);
                                pcount_next = CW'(1);
                                state_next  = S_NWAIT;
                            end
                            else
                            begin
                                state_next = S_LRD;
                            end
                        end
                        MODE_QUERY:
                        begin
                            if (err_reg)
                            begin
                                st_next    = ST_ERROR;
                                state_next = S_OUT;
                            end
                            else if (pcount_reg == '0 || bcount_reg == '0)
                            begin
                                st_next    = ST_NONE;
                                state_next = S_OUT;
                            end
                            else
                            begin
                                // lower edge: floor((pos - tol - base)/w)
                                lo_neg = ({1'b0, position} < ({1'b0, tolerance}
                                          + {1'b0, base_reg}));
                                if (lo_neg)
                                begin
                                    lo_mag = {1'b0, tolerance} + {1'b0, base_reg}
                                             - {1'b0, position};
                                end
                                else
                                begin
                                    lo_mag = {1'b0, position} - {1'b0, tolerance}
                                             - {1'b0, base_reg};
                                end
                                dreq.go       = 1'b1;
                                dreq.dividend = lo_mag;
                                dreq.divisor  = wused;
                                lo_next       = {33'd0, lo_neg};
                                state_next    = S_QLO;
                            end
                        end
                        default:
                        begin
                            state_next = S_NWAIT;
                        end
                    endcase
                end
            end

            S_NWAIT:
            begin
                state_next = S_IDLE;
            end

            S_LRD:
            begin
                pk_addr    = pc_m1[PW-1:0];
                state_next = S_LCHK;
            end

            S_LCHK:
            begin
                if (pcount_reg >= CW'(MAX_PEAKS) || pos_reg < pk_rdata)
                begin
                    err_next   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    dreq.go       = 1'b1;
                    dreq.dividend = {1'b0, pos_reg - base_reg};
                    dreq.divisor  = wused;
                    state_next    = S_LDIV;
                end
            end

            S_LDIV:
            begin
                if (drsp.done)
                begin
                    if (drsp.quotient >= 33'(MAX_BINS))
                    begin
                        err_next   = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        lo_next = {1'b0, drsp.quotient};
                        if (drsp.quotient >= {{(33-NW){1'b0}}, bcount_reg})
                        begin
                            idx_next   = bcount_reg;
                            state_next = S_LFILL;
                        end
                        else
                        begin
                            idx_next   = bcount_reg - NW'(1);
                            state_next = S_LSTORE;
                        end
                    end
                end
            end

            S_LFILL:
            begin
                // empty bins up to the target, then open the target
                bf_we    = 1'b1;
                bf_wdata = pcount_reg;
                if ({{(34-NW){1'b0}}, idx_reg} == lo_reg)
                begin
                    bcount_next = idx_reg + NW'(1);
                    state_next  = S_LSTORE;
                end
                else
                begin
                    bl_we    = 1'b1;
                    bl_wdata = pcount_reg;
                    idx_next = idx_reg + NW'(1);
                end
            end

            S_LSTORE:
            begin
                pk_we       = 1'b1;
                pk_addr     = pcount_reg[PW-1:0];
                pk_wdata    = pos_reg;
                pcount_next = pcount_reg + CW'(1);
                bl_we       = 1'b1;
                bl_wdata    = pcount_reg + CW'(1);
                bn_addr     = idx_reg[BW-1:0];
                state_next  = S_IDLE;
            end

            S_QLO:
            begin
                if (drsp.done)
                begin
                    // lo_reg[0] held the sign of the lower edge
                    if (lo_reg[0])
                    begin
                        lo_next = '0 - (q_ext + {33'd0, !drsp.exact});
                    end
                    else
                    begin
                        lo_next = q_ext;
                    end
                    hi_sum = {1'b0, pos_reg} + {1'b0, tol_reg};
                    if (hi_sum < {1'b0, base_reg})
                    begin
                        dreq.dividend = {1'b0, base_reg} - hi_sum;
                        hi_next       = 34'd1;
                    end
                    else
                    begin
                        dreq.dividend = hi_sum - {1'b0, base_reg};
                        hi_next       = 34'd0;
                    end
                    dreq.go     = 1'b1;
                    dreq.divisor = wused;
                    state_next  = S_QHI;
                end
            end

            S_QHI:
            begin
                if (drsp.done)
                begin
                    if (hi_reg[0])
                    begin
                        hi_next = '0 - (q_ext + {33'd0, !drsp.exact});
                    end
                    else
                    begin
                        hi_next = q_ext;
                    end
                    state_next = S_QCLAMP;
                end
            end

            S_QCLAMP:
            begin
                if (hi_reg[33] || (!lo_reg[33] && lo_reg >= bc_ext))
                begin
                    st_next    = ST_NONE;
                    state_next = S_OUT;
                end
                else
                begin
                    if (lo_reg[33])
                    begin
                        lo_next = '0;
                    end
                    if (hi_reg >= bc_ext)
                    begin
                        hi_next = bc_ext - 34'd1;
                    end
                    state_next = S_SFRD;
                end
            end

            S_SFRD:
            begin
                bn_addr    = lo_reg[BW-1:0];
                state_next = S_SFCHK;
            end

            S_SFCHK:
            begin
                if (bf_rdata < bl_rdata)
                begin
                    left_next  = bf_rdata;
                    state_next = S_SBRD;
                end
                else if (lo_reg == hi_reg)
                begin
                    st_next    = ST_NONE;
                    state_next = S_OUT;
                end
                else
                begin
                    lo_next    = lo_reg + 34'd1;
                    state_next = S_SFRD;
                end
            end

            S_SBRD:
            begin
                bn_addr    = hi_reg[BW-1:0];
                state_next = S_SBCHK;
            end

            S_SBCHK:
            begin
                // an occupied bin exists at or above lo, so this ends
                if (bf_rdata < bl_rdata)
                begin
                    right_next = bl_rdata;
                    state_next = S_BSRD;
                end
                else
                begin
                    hi_next    = hi_reg - 34'd1;
                    state_next = S_SBRD;
                end
            end

            S_BSRD:
            begin
                if (left_reg < right_reg)
                begin
                    pk_addr    = mid[PW-1:0];
                    state_next = S_BSCHK;
                end
                else
                begin
                    state_next = S_NRD;
                end
            end

            S_BSCHK:
            begin
                if (pk_rdata < pos_reg)
                begin
                    left_next = mid + CW'(1);
                end
                else
                begin
                    right_next = mid;
                end
                state_next = S_BSRD;
            end

            S_NRD:
            begin
                st_next = ST_FOUND;
                if (left_reg == '0)
                begin
                    left_next = '0;
                    pk_addr   = '0;
                    state_next = S_NPICK;
                    right_next = '0;
                end
                else if (left_reg >= pcount_reg)
                begin
                    left_next  = pc_m1;
                    pk_addr    = pc_m1[PW-1:0];
                    right_next = '0;
                    state_next = S_NPICK;
                end
                else
                begin
                    pk_addr    = left_reg[PW-1:0];
                    right_next = CW'(1);
                    state_next = S_NRD2;
                end
            end

            S_NRD2:
            begin
                cand_next  = pk_rdata;
                pk_addr    = left_reg[PW-1:0] - PW'(1);
                state_next = S_NPICK;
            end

            S_NPICK:
            begin
                // right_reg flags a two-way comparison
                if (right_reg == '0)
                begin
                    pi_next = 10'(left_reg);
                    pp_next = pk_rdata;
                end
                else
                begin
                    d_cur  = (cand_reg >= pos_reg) ? cand_reg - pos_reg
                                                   : pos_reg - cand_reg;
                    d_prev = (pk_rdata >= pos_reg) ? pk_rdata - pos_reg
                                                   : pos_reg - pk_rdata;
                    if (d_cur < d_prev)
                    begin
                        pi_next = 10'(left_reg);
                        pp_next = cand_reg;
                    end
                    else
                    begin
                        pi_next = 10'(left_reg - CW'(1));
                        pp_next = pk_rdata;
                    end
                end
                rv_next    = 1'b1;
                state_next = S_IDLE;
            end

            S_OUT:
            begin
                pi_next    = '0;
                pp_next    = '0;
                rv_next    = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            width_reg  <= 32'd65536;
            pcount_reg <= '0;
            bcount_reg <= '0;
            base_reg   <= '0;
            err_reg    <= 1'b0;
            rv_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            width_reg  <= width_next;
            pcount_reg <= pcount_next;
            bcount_reg <= bcount_next;
            base_reg   <= base_next;
            err_reg    <= err_next;
            rv_reg     <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg   <= pos_next;
        tol_reg   <= tol_next;
        idx_reg   <= idx_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        left_reg  <= left_next;
        right_reg <= right_next;
        cand_reg  <= cand_next;
        st_reg    <= st_next;
        pi_reg    <= pi_next;
        pp_reg    <= pp_next;
    end

    assign result_valid  = rv_reg;
    assign status        = st_reg;
    assign peak_index    = pi_reg;
    assign peak_position = pp_reg;
endmodule
